// ----- sv/round_robin_time_slice_scheduler_top_defines.svh -----
// assertion macros shared by the scheduler modules
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_TOP_DEFINES_SVH

// checked at every rising clock edge, off while in reset
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// checked at every rising clock edge, reset included
`define RRTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- sv/rrts_pkg.sv -----
package rrts_pkg;

  localparam int IdW    = 8;
  localparam int BurstW = 16;
  localparam int TimeW  = 32;
  localparam int QuantW = 8;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [QuantW-1:0] QUANTUM_RESET = 8'd3;

  typedef enum logic [1:0] {
    STAT_QUEUED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_IDLE    = 2'd2,
    STAT_RAN     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REREAD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]    ident;
    logic [BurstW-1:0] burst;
    logic [BurstW-1:0] left;
    logic [TimeW-1:0]  arrival;
  } entry_t;

  typedef struct packed {
    logic arrive;
    logic idle_tick;
    logic tick_start;
    logic rotate;
    logic reread;
    logic run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic slice_expired;
    logic out_valid;
  } sts_t;

endpackage

// ----- sv/rrts_ram.sv -----
module rrts_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rrts_ctrl.sv -----
`include "round_robin_time_slice_scheduler_top_defines.svh"

module rrts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           op_i,
  input  logic           out_stall_i,
  input  rrts_pkg::sts_t sts_i,
  output logic           in_stall_o,
  output rrts_pkg::cmd_t cmd_o
);
  import rrts_pkg::*;

  state_e state_q, state_d;
  logic   rotated_q, rotated_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE) || (sts_i.out_valid && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    rotated_d = rotated_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OP_TICK) && !sts_i.empty) begin
          state_d   = S_EXEC;
          rotated_d = 1'b0;
        end
      end
      S_EXEC: begin
        if (sts_i.slice_expired && !rotated_q) begin
          state_d   = S_REREAD;
          rotated_d = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REREAD: state_d = S_EXEC;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_ARRIVE) begin
            cmd_o.arrive = 1'b1;
          end else if (sts_i.empty) begin
            cmd_o.idle_tick = 1'b1;
          end else begin
            cmd_o.tick_start = 1'b1;
          end
        end
      end
      S_EXEC: begin
        if (sts_i.slice_expired && !rotated_q) begin
          cmd_o.rotate = 1'b1;
        end else begin
          cmd_o.run = 1'b1;
        end
      end
      S_REREAD: cmd_o.reread = 1'b1;
      S_DONE:   cmd_o.finish = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rotated_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rotated_q <= rotated_d;
    end
  end

  `RRTS_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "more than one datapath command")
  `RRTS_ASSERT(a_done_out_free, (state_q == S_DONE) |-> !sts_i.out_valid,
    "result lands on an occupied output")
  `RRTS_ASSERT(a_single_rotate, cmd_o.rotate |=> cmd_o.reread ##1 cmd_o.run,
    "head rotated more than once in a tick")

endmodule

// ----- sv/rrts_dp.sv -----
`include "round_robin_time_slice_scheduler_top_defines.svh"

module rrts_dp #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rrts_pkg::cmd_t                       cmd_i,
  output rrts_pkg::sts_t                       sts_o,
  input  logic                                 quantum_we_i,
  input  logic [rrts_pkg::QuantW-1:0]          quantum_i,
  input  logic [rrts_pkg::IdW-1:0]             proc_id_i,
  input  logic [rrts_pkg::BurstW-1:0]          burst_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [1:0]                           status_o,
  output logic [rrts_pkg::IdW-1:0]             run_id_o,
  output logic [rrts_pkg::TimeW-1:0]           now_o,
  output logic                                 started_o,
  output logic                                 finished_o,
  output logic [rrts_pkg::TimeW-1:0]           turnaround_o,
  output logic [rrts_pkg::TimeW-1:0]           waiting_o
);
  import rrts_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int OccW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(QUEUE_DEPTH);

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    ring_next = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  logic [QuantW-1:0] quantum_q;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [QuantW-1:0] slice_q, slice_d;
  logic [TimeW-1:0]  clock_q, clock_d;
  logic              out_valid_q, out_valid_d;

  status_e           status_q;
  logic [IdW-1:0]    run_id_q;
  logic [TimeW-1:0]  now_q, turn_q, wait_q;
  logic              started_q, finished_q;
  logic [BurstW-1:0] burst_q;

  logic              full, empty, fin;
  logic              ram_we, ram_re;
  logic [PtrW-1:0]   ram_waddr;
  entry_t            ram_wdata, rd_entry, new_entry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  assign full     = (occ_q == FullOcc);
  assign empty    = (occ_q == '0);
  assign rd_entry = entry_t'(ram_rdata);
  assign fin      = (rd_entry.left <= BurstW'(1));

  assign sts_o.empty         = empty;
  assign sts_o.slice_expired = (slice_q >= quantum_q);
  assign sts_o.out_valid     = out_valid_q;

  always_comb begin
    new_entry.ident   = proc_id_i;
    new_entry.burst   = burst_i;
    new_entry.left    = burst_i;
    new_entry.arrival = clock_q;
  end

  // one write port: arrival and rotation go to the tail, run updates the head
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_q;
    ram_wdata = new_entry;
    if (cmd_i.arrive && !full) begin
      ram_we = 1'b1;
    end else if (cmd_i.rotate) begin
      ram_we    = 1'b1;
      ram_wdata = rd_entry;
    end else if (cmd_i.run) begin
      ram_we         = 1'b1;
      ram_waddr      = head_q;
      ram_wdata      = rd_entry;
      ram_wdata.left = fin ? '0 : rd_entry.left - BurstW'(1);
    end
  end

  assign ram_re = cmd_i.tick_start || cmd_i.reread;

  rrts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    slice_d     = slice_q;
    clock_d     = clock_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.arrive) begin
      out_valid_d = 1'b1;
      if (!full) begin
        tail_d = ring_next(tail_q);
        occ_d  = occ_q + OccW'(1);
      end
    end
    if (cmd_i.idle_tick) begin
      clock_d     = clock_q + TimeW'(1);
      slice_d     = '0;
      out_valid_d = 1'b1;
    end
    if (cmd_i.tick_start) begin
      clock_d = clock_q + TimeW'(1);
    end
    if (cmd_i.rotate) begin
      head_d  = ring_next(head_q);
      tail_d  = ring_next(tail_q);
      slice_d = '0;
    end
    if (cmd_i.run) begin
      if (fin) begin
        head_d  = ring_next(head_q);
        occ_d   = occ_q - OccW'(1);
        slice_d = '0;
      end else begin
        slice_d = slice_q + QuantW'(1);
      end
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= QUANTUM_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      slice_q     <= '0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (quantum_we_i) begin
        quantum_q <= quantum_i;
      end
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      slice_q     <= slice_d;
      clock_q     <= clock_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result registers, written only while the output is free
  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive) begin
      status_q   <= full ? STAT_DROPPED : STAT_QUEUED;
      run_id_q   <= '0;
      now_q      <= clock_q;
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      turn_q     <= '0;
      wait_q     <= '0;
    end
    if (cmd_i.idle_tick) begin
      status_q   <= STAT_IDLE;
      run_id_q   <= '0;
      now_q      <= clock_q + TimeW'(1);
      started_q  <= 1'b0;
      finished_q <= 1'b0;
      turn_q     <= '0;
      wait_q     <= '0;
    end
    if (cmd_i.run) begin
      status_q   <= STAT_RAN;
      run_id_q   <= rd_entry.ident;
      now_q      <= clock_q;
      started_q  <= (rd_entry.left == rd_entry.burst);
      finished_q <= fin;
      turn_q     <= fin ? clock_q - rd_entry.arrival : '0;
      burst_q    <= rd_entry.burst;
    end
    if (cmd_i.finish) begin
      wait_q <= finished_q ? turn_q - TimeW'(burst_q) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign run_id_o     = run_id_q;
  assign now_o        = now_q;
  assign started_o    = started_q;
  assign finished_o   = finished_q;
  assign turnaround_o = turn_q;
  assign waiting_o    = wait_q;

  `RRTS_ASSERT(a_occ_bound, occ_q <= FullOcc, "occupancy above queue depth")
  `RRTS_ASSERT(a_ptr_meet, (empty || full) |-> (head_q == tail_q),
    "pointers disagree with occupancy")
  `RRTS_ASSERT(a_run_nonempty, (cmd_i.run || cmd_i.rotate) |-> !empty,
    "entry used from an empty queue")

endmodule

// ----- sv/round_robin_time_slice_scheduler_top.sv -----
// channel   direction  handshake                   payload
// input     in         in_valid_i / in_stall_o     op_i, proc_id_i, burst_i
// result    out        out_valid_o / out_stall_i   status_o .. waiting_o
// config    in         quantum_we_i                quantum_i
//
// an arrival or an idle tick is handled straight from idle; a tick that runs a
// process reads the queue ram, executes and subtracts the waiting time, and if
// the head is rotated first, the single-read ram is read again at the new head
// before the execute. reset clears pointers, occupancy, slice, clock and valid
// flag, sets the quantum to 3; the queue ram is not cleared, entries are read
// only while occupied. a held result stalls the input only until it is taken.
module round_robin_time_slice_scheduler_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [rrts_pkg::IdW-1:0]    proc_id_i,
  input  logic [rrts_pkg::BurstW-1:0] burst_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [rrts_pkg::IdW-1:0]    run_id_o,
  output logic [rrts_pkg::TimeW-1:0]  now_o,
  output logic                        started_o,
  output logic                        finished_o,
  output logic [rrts_pkg::TimeW-1:0]  turnaround_o,
  output logic [rrts_pkg::TimeW-1:0]  waiting_o,
  input  logic                        quantum_we_i,
  input  logic [rrts_pkg::QuantW-1:0] quantum_i
);
  import rrts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  rrts_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .quantum_we_i (quantum_we_i),
    .quantum_i    (quantum_i),
    .proc_id_i    (proc_id_i),
    .burst_i      (burst_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .run_id_o     (run_id_o),
    .now_o        (now_o),
    .started_o    (started_o),
    .finished_o   (finished_o),
    .turnaround_o (turnaround_o),
    .waiting_o    (waiting_o)
  );

endmodule
